### rtl/hrzpt_pkg.sv
// Package for the heart-rate zone and peak tracker.
// Holds field widths, saturation limits, register indexes and the zone weight table.
// No dependencies.
package hrzpt_pkg;

	// default width of sample and peak times
	localparam int TIME_BITS_DEF = 17;

	// fixed field widths
	localparam int HR_W    = 8;
	localparam int ZONE_W  = 3;
	localparam int PEAKS_W = 16;
	localparam int COUNT_W = 17;
	localparam int SUM_W   = 25;
	localparam int LOAD_W  = 21;
	localparam int WGT_W   = 4;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_BOUND_ZONE1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_ZONE2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_ZONE3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_ZONE4 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_ZONE5 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_TOP   = 3'd5;

	// bound reset values in bpm
	localparam logic [HR_W-1:0] BOUND_ZONE1_RST = 8'd95;
	localparam logic [HR_W-1:0] BOUND_ZONE2_RST = 8'd114;
	localparam logic [HR_W-1:0] BOUND_ZONE3_RST = 8'd133;
	localparam logic [HR_W-1:0] BOUND_ZONE4_RST = 8'd152;
	localparam logic [HR_W-1:0] BOUND_ZONE5_RST = 8'd171;
	localparam logic [HR_W-1:0] BOUND_TOP_RST   = 8'd190;

	// saturation limits
	localparam logic [PEAKS_W-1:0] PEAKS_MAX = 16'd65535;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd131071;
	localparam logic [SUM_W-1:0]   SUM_MAX   = 25'd33423105;
	localparam logic [LOAD_W-1:0]  LOAD_MAX  = 21'd1310710;

	// zone codes
	localparam logic [ZONE_W-1:0] ZONE_REST  = 3'd0;
	localparam logic [ZONE_W-1:0] ZONE_1     = 3'd1;
	localparam logic [ZONE_W-1:0] ZONE_2     = 3'd2;
	localparam logic [ZONE_W-1:0] ZONE_3     = 3'd3;
	localparam logic [ZONE_W-1:0] ZONE_4     = 3'd4;
	localparam logic [ZONE_W-1:0] ZONE_5     = 3'd5;
	localparam logic [ZONE_W-1:0] ZONE_ABOVE = 3'd6;

	// TRIMP weight in half units for each zone; above the top bound adds nothing
	function automatic logic [WGT_W-1:0] zone_weight(input logic [ZONE_W-1:0] zone);
		logic [WGT_W-1:0] w;
		unique case (zone)
			ZONE_REST: w = 4'd1;
			ZONE_1:    w = 4'd2;
			ZONE_2:    w = 4'd4;
			ZONE_3:    w = 4'd6;
			ZONE_4:    w = 4'd8;
			ZONE_5:    w = 4'd10;
			default:   w = 4'd0;
		endcase
		return w;
	endfunction

endpackage

### rtl/heart_rate_zone_peak_tracker.sv
// Heart-rate zone and peak tracker, top level.
// Depends on hrzpt_pkg for widths, limits, register indexes and the weight table.
// Each accepted sample word yields exactly one result word, in order. A word
// passes the input register, then the classification, peak and statistics
// logic updates the running state and loads the result register. A new sample
// is taken every cycle while the output side takes results; the result register
// stalls only when m_tready is low. start_req clears all statistics before its
// own sample is processed. The user must write the zone bounds through the cfg
// port only while no sample is in flight; the block itself does not enforce it.
module heart_rate_zone_peak_tracker #(
	parameter int TIME_BITS = hrzpt_pkg::TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [hrzpt_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [hrzpt_pkg::CFG_DATA_W-1:0]    cfg_data,
	// sample stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata from bit 0: hr, time_s, zero fill
	input  logic [((hrzpt_pkg::HR_W+TIME_BITS+7)/8)*8-1:0] s_tdata,
	// tuser: start_req
	input  logic                                s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata from bit 0: zone, peak_hr, peak_time, peak_count, min_hr, min_time,
	// max_hr, max_time, sample_count, hr_sum, trimp_half, zero fill
	output logic [((3*TIME_BITS+106+7)/8)*8-1:0] m_tdata,
	// tuser: peak_found
	output logic                                m_tuser
);

	localparam int HR_W    = hrzpt_pkg::HR_W;
	localparam int ZONE_W  = hrzpt_pkg::ZONE_W;
	localparam int PEAKS_W = hrzpt_pkg::PEAKS_W;
	localparam int COUNT_W = hrzpt_pkg::COUNT_W;
	localparam int SUM_W   = hrzpt_pkg::SUM_W;
	localparam int LOAD_W  = hrzpt_pkg::LOAD_W;
	localparam int OUT_BITS = ZONE_W + HR_W + TIME_BITS + PEAKS_W + HR_W + TIME_BITS
		+ HR_W + TIME_BITS + COUNT_W + SUM_W + LOAD_W;
	localparam int OUT_W = ((3*TIME_BITS+106+7)/8)*8;

	// configuration registers
	logic [HR_W-1:0] bound_zone1_q, bound_zone2_q, bound_zone3_q;
	logic [HR_W-1:0] bound_zone4_q, bound_zone5_q, bound_top_q;

	// input stage
	logic                 valid_s1;
	logic [HR_W-1:0]      hr_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 start_s1;

	// running state
	logic [HR_W-1:0]      last_rate_q;
	logic                 record_open_q;
	logic                 cand_valid_q;
	logic [HR_W-1:0]      cand_rate_q;
	logic [TIME_BITS-1:0] cand_time_q;
	logic [PEAKS_W-1:0]   peak_total_q;
	logic [HR_W-1:0]      low_rate_q, high_rate_q;
	logic [TIME_BITS-1:0] low_time_q, high_time_q;
	logic [COUNT_W-1:0]   count_total_q;
	logic [SUM_W-1:0]     rate_total_q;
	logic [LOAD_W-1:0]    load_total_q;

	// result stage
	logic                 valid_s2;
	logic                 found_s2;
	logic [OUT_BITS-1:0]  result_s2;

	// next-state values
	logic                 cand_valid_d;
	logic [HR_W-1:0]      cand_rate_d;
	logic [TIME_BITS-1:0] cand_time_d;
	logic [PEAKS_W-1:0]   peak_total_d;
	logic [HR_W-1:0]      low_rate_d, high_rate_d;
	logic [TIME_BITS-1:0] low_time_d, high_time_d;
	logic [COUNT_W-1:0]   count_total_d;
	logic [SUM_W-1:0]     rate_total_d;
	logic [LOAD_W-1:0]    load_total_d;
	logic [ZONE_W-1:0]    zone_d;
	logic                 found_d;
	logic [HR_W-1:0]      peak_hr_d;
	logic [TIME_BITS-1:0] peak_time_d;

	logic advance;

	// move the input word forward when the result register is free or drains
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tuser  = found_s2;
	assign m_tdata  = OUT_W'(result_s2);

	// write the zone bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_zone1_q <= hrzpt_pkg::BOUND_ZONE1_RST;
			bound_zone2_q <= hrzpt_pkg::BOUND_ZONE2_RST;
			bound_zone3_q <= hrzpt_pkg::BOUND_ZONE3_RST;
			bound_zone4_q <= hrzpt_pkg::BOUND_ZONE4_RST;
			bound_zone5_q <= hrzpt_pkg::BOUND_ZONE5_RST;
			bound_top_q   <= hrzpt_pkg::BOUND_TOP_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				hrzpt_pkg::REG_BOUND_ZONE1: bound_zone1_q <= cfg_data;
				hrzpt_pkg::REG_BOUND_ZONE2: bound_zone2_q <= cfg_data;
				hrzpt_pkg::REG_BOUND_ZONE3: bound_zone3_q <= cfg_data;
				hrzpt_pkg::REG_BOUND_ZONE4: bound_zone4_q <= cfg_data;
				hrzpt_pkg::REG_BOUND_ZONE5: bound_zone5_q <= cfg_data;
				hrzpt_pkg::REG_BOUND_TOP:   bound_top_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			hr_s1    <= s_tdata[HR_W-1:0];
			time_s1  <= s_tdata[HR_W +: TIME_BITS];
			start_s1 <= s_tuser;
		end
	end

	// classify the sample, track extremes and peaks, accumulate totals
	always_comb begin
		logic                 open_e;
		logic                 cv_e;
		logic [HR_W-1:0]      last_e, cr_e, low_e, high_e;
		logic [TIME_BITS-1:0] ct_e, lowt_e, hight_e;
		logic [PEAKS_W-1:0]   peaks_e;
		logic [COUNT_W-1:0]   count_e;
		logic [SUM_W-1:0]     rate_e;
		logic [LOAD_W-1:0]    load_e;
		logic [PEAKS_W:0]     peaks_sum;
		logic [COUNT_W:0]     count_sum;
		logic [SUM_W:0]       rate_sum;
		logic [LOAD_W:0]      load_sum;

		// a start request sees cleared statistics
		open_e  = start_s1 ? 1'b0 : record_open_q;
		cv_e    = start_s1 ? 1'b0 : cand_valid_q;
		last_e  = start_s1 ? '0 : last_rate_q;
		cr_e    = start_s1 ? '0 : cand_rate_q;
		ct_e    = start_s1 ? '0 : cand_time_q;
		peaks_e = start_s1 ? '0 : peak_total_q;
		low_e   = start_s1 ? '0 : low_rate_q;
		lowt_e  = start_s1 ? '0 : low_time_q;
		high_e  = start_s1 ? '0 : high_rate_q;
		hight_e = start_s1 ? '0 : high_time_q;
		count_e = start_s1 ? '0 : count_total_q;
		rate_e  = start_s1 ? '0 : rate_total_q;
		load_e  = start_s1 ? '0 : load_total_q;

		// zone by the compare chain, in order
		priority if (hr_s1 < bound_zone1_q) zone_d = hrzpt_pkg::ZONE_REST;
		else if (hr_s1 < bound_zone2_q)     zone_d = hrzpt_pkg::ZONE_1;
		else if (hr_s1 < bound_zone3_q)     zone_d = hrzpt_pkg::ZONE_2;
		else if (hr_s1 < bound_zone4_q)     zone_d = hrzpt_pkg::ZONE_3;
		else if (hr_s1 < bound_zone5_q)     zone_d = hrzpt_pkg::ZONE_4;
		else if (hr_s1 <= bound_top_q)      zone_d = hrzpt_pkg::ZONE_5;
		else                                zone_d = hrzpt_pkg::ZONE_ABOVE;

		// minimum and maximum, first occurrence wins
		low_rate_d  = low_e;
		low_time_d  = lowt_e;
		high_rate_d = high_e;
		high_time_d = hight_e;
		if (!open_e || hr_s1 < low_e) begin
			low_rate_d = hr_s1;
			low_time_d = time_s1;
		end
		if (!open_e || hr_s1 > high_e) begin
			high_rate_d = hr_s1;
			high_time_d = time_s1;
		end

		// confirm or drop the candidate
		found_d      = 1'b0;
		cand_valid_d = cv_e;
		cand_rate_d  = cr_e;
		cand_time_d  = ct_e;
		peak_total_d = peaks_e;
		peaks_sum    = {1'b0, peaks_e} + (PEAKS_W+1)'(1);
		if (cv_e) begin
			if (hr_s1 < cr_e) begin
				found_d      = 1'b1;
				cand_valid_d = 1'b0;
				peak_total_d = (peaks_sum > {1'b0, hrzpt_pkg::PEAKS_MAX})
					? hrzpt_pkg::PEAKS_MAX : peaks_sum[PEAKS_W-1:0];
			end else if (hr_s1 > cr_e) begin
				cand_valid_d = 1'b0;
			end
		end
		peak_hr_d   = found_d ? cr_e : '0;
		peak_time_d = found_d ? ct_e : '0;

		// start a new candidate on a rise at or above the first bound
		if (!cand_valid_d && open_e && hr_s1 > last_e && hr_s1 >= bound_zone1_q) begin
			cand_valid_d = 1'b1;
			cand_rate_d  = hr_s1;
			cand_time_d  = time_s1;
		end

		// saturating totals
		count_sum = {1'b0, count_e} + (COUNT_W+1)'(1);
		count_total_d = (count_sum > {1'b0, hrzpt_pkg::COUNT_MAX})
			? hrzpt_pkg::COUNT_MAX : count_sum[COUNT_W-1:0];
		rate_sum = {1'b0, rate_e} + (SUM_W+1)'(hr_s1);
		rate_total_d = (rate_sum > {1'b0, hrzpt_pkg::SUM_MAX})
			? hrzpt_pkg::SUM_MAX : rate_sum[SUM_W-1:0];
		load_sum = {1'b0, load_e} + (LOAD_W+1)'(hrzpt_pkg::zone_weight(zone_d));
		load_total_d = (load_sum > {1'b0, hrzpt_pkg::LOAD_MAX})
			? hrzpt_pkg::LOAD_MAX : load_sum[LOAD_W-1:0];
	end

	// update running state as the word enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rate_q   <= '0;
			record_open_q <= 1'b0;
			cand_valid_q  <= 1'b0;
			cand_rate_q   <= '0;
			cand_time_q   <= '0;
			peak_total_q  <= '0;
			low_rate_q    <= '0;
			low_time_q    <= '0;
			high_rate_q   <= '0;
			high_time_q   <= '0;
			count_total_q <= '0;
			rate_total_q  <= '0;
			load_total_q  <= '0;
		end else if (valid_s1 && advance) begin
			last_rate_q   <= hr_s1;
			record_open_q <= 1'b1;
			cand_valid_q  <= cand_valid_d;
			cand_rate_q   <= cand_rate_d;
			cand_time_q   <= cand_time_d;
			peak_total_q  <= peak_total_d;
			low_rate_q    <= low_rate_d;
			low_time_q    <= low_time_d;
			high_rate_q   <= high_rate_d;
			high_time_q   <= high_time_d;
			count_total_q <= count_total_d;
			rate_total_q  <= rate_total_d;
			load_total_q  <= load_total_d;
		end
	end

	// result register, held while the output side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			found_s2  <= found_d;
			result_s2 <= {load_total_d, rate_total_d, count_total_d,
				high_time_d, high_rate_d, low_time_d, low_rate_d,
				peak_total_d, peak_time_d, peak_hr_d, zone_d};
		end
	end

endmodule

### tb/heart_rate_zone_peak_tracker_tb.sv
// Self-checking testbench for heart_rate_zone_peak_tracker: zone edges, peak shapes,
// bound extremes and random workouts under several idle and stall patterns.
// Depends on hrzpt_pkg and the tracker RTL only.
`timescale 1ns / 100ps

module heart_rate_zone_peak_tracker_tb;
	import hrzpt_pkg::*;

	localparam int TIME_W = TIME_BITS_DEF;
	localparam int S_W = ((HR_W + TIME_W + 7) / 8) * 8;
	localparam int M_W = ((3 * TIME_W + 106 + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_CAP = 40;
	localparam int unsigned ZONE_LOAD [7] = '{1, 2, 4, 6, 8, 10, 0};

	// result word fields, last declared field sits at bit 0
	typedef struct packed {
		logic [LOAD_W-1:0]  trimp_half;
		logic [SUM_W-1:0]   hr_sum;
		logic [COUNT_W-1:0] sample_count;
		logic [TIME_W-1:0]  max_time;
		logic [HR_W-1:0]    max_hr;
		logic [TIME_W-1:0]  min_time;
		logic [HR_W-1:0]    min_hr;
		logic [PEAKS_W-1:0] peak_count;
		logic [TIME_W-1:0]  peak_time;
		logic [HR_W-1:0]    peak_hr;
		logic [ZONE_W-1:0]  zone;
	} stats_word_t;

	typedef struct packed {
		logic        peak_found;
		stats_word_t w;
	} sample_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [S_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_W-1:0] m_tdata;
	logic m_tuser;

	heart_rate_zone_peak_tracker #(
		.TIME_BITS(TIME_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// tracker state mirrored by the predictor
	logic [HR_W-1:0]    bound_bpm [6];
	logic [HR_W-1:0]    prev_hr = '0;
	logic               have_prev = 1'b0;
	logic               peak_armed = 1'b0;
	logic [HR_W-1:0]    peak_rate = '0;
	logic [TIME_W-1:0]  peak_start = '0;
	logic [PEAKS_W-1:0] peaks_seen = '0;
	logic [HR_W-1:0]    lo_hr = '0;
	logic [TIME_W-1:0]  lo_t = '0;
	logic [HR_W-1:0]    hi_hr = '0;
	logic [TIME_W-1:0]  hi_t = '0;
	logic [COUNT_W-1:0] n_samples = '0;
	logic [SUM_W-1:0]   rate_acc = '0;
	logic [LOAD_W-1:0]  load_acc = '0;

	sample_result_t pending_results [$];
	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned quiet_cycles = 0;
	logic [TIME_W-1:0] workout_s = '0;

	initial begin
		bound_bpm[REG_BOUND_ZONE1] = BOUND_ZONE1_RST;
		bound_bpm[REG_BOUND_ZONE2] = BOUND_ZONE2_RST;
		bound_bpm[REG_BOUND_ZONE3] = BOUND_ZONE3_RST;
		bound_bpm[REG_BOUND_ZONE4] = BOUND_ZONE4_RST;
		bound_bpm[REG_BOUND_ZONE5] = BOUND_ZONE5_RST;
		bound_bpm[REG_BOUND_TOP]   = BOUND_TOP_RST;
	end

	// advance the mirrored tracker by one sample and return the expected result word
	function automatic sample_result_t track_sample(input logic [HR_W-1:0] hr,
			input logic [TIME_W-1:0] ts, input logic restart);
		sample_result_t r;
		logic [ZONE_W-1:0] z;
		int unsigned acc;
		r = '0;
		if (restart) begin
			prev_hr = '0;
			have_prev = 1'b0;
			peak_armed = 1'b0;
			peak_rate = '0;
			peak_start = '0;
			peaks_seen = '0;
			lo_hr = '0;
			lo_t = '0;
			hi_hr = '0;
			hi_t = '0;
			n_samples = '0;
			rate_acc = '0;
			load_acc = '0;
		end
		// compare chain in order, bounds need not be sorted
		if (hr < bound_bpm[REG_BOUND_ZONE1])
			z = ZONE_REST;
		else if (hr < bound_bpm[REG_BOUND_ZONE2])
			z = ZONE_1;
		else if (hr < bound_bpm[REG_BOUND_ZONE3])
			z = ZONE_2;
		else if (hr < bound_bpm[REG_BOUND_ZONE4])
			z = ZONE_3;
		else if (hr < bound_bpm[REG_BOUND_ZONE5])
			z = ZONE_4;
		else if (hr <= bound_bpm[REG_BOUND_TOP])
			z = ZONE_5;
		else
			z = ZONE_ABOVE;
		// min and max keep the first time of their value
		if (!have_prev) begin
			lo_hr = hr;
			lo_t = ts;
			hi_hr = hr;
			hi_t = ts;
		end else begin
			if (hr < lo_hr) begin
				lo_hr = hr;
				lo_t = ts;
			end
			if (hr > hi_hr) begin
				hi_hr = hr;
				hi_t = ts;
			end
		end
		// a lower sample confirms the candidate, a higher one drops it
		if (peak_armed) begin
			if (hr < peak_rate) begin
				r.peak_found = 1'b1;
				r.w.peak_hr = peak_rate;
				r.w.peak_time = peak_start;
				if (peaks_seen != PEAKS_MAX)
					peaks_seen = peaks_seen + 1'b1;
				peak_armed = 1'b0;
			end else if (hr > peak_rate) begin
				peak_armed = 1'b0;
			end
		end
		if (!peak_armed && have_prev && hr > prev_hr && hr >= bound_bpm[REG_BOUND_ZONE1]) begin
			peak_armed = 1'b1;
			peak_rate = hr;
			peak_start = ts;
		end
		// saturating totals
		if (n_samples != COUNT_MAX)
			n_samples = n_samples + 1'b1;
		acc = rate_acc + hr;
		rate_acc = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
		acc = load_acc + ZONE_LOAD[z];
		load_acc = (acc > LOAD_MAX) ? LOAD_MAX : acc[LOAD_W-1:0];
		prev_hr = hr;
		have_prev = 1'b1;

		r.w.zone = z;
		r.w.peak_count = peaks_seen;
		r.w.min_hr = lo_hr;
		r.w.min_time = lo_t;
		r.w.max_hr = hi_hr;
		r.w.max_time = hi_t;
		r.w.sample_count = n_samples;
		r.w.hr_sum = rate_acc;
		r.w.trimp_half = load_acc;
		return r;
	endfunction

	task automatic flag_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result(input sample_result_t want, input sample_result_t got);
		flag_field("peak_found", want.peak_found, got.peak_found);
		flag_field("zone", want.w.zone, got.w.zone);
		flag_field("peak_hr", want.w.peak_hr, got.w.peak_hr);
		flag_field("peak_time", want.w.peak_time, got.w.peak_time);
		flag_field("peak_count", want.w.peak_count, got.w.peak_count);
		flag_field("min_hr", want.w.min_hr, got.w.min_hr);
		flag_field("min_time", want.w.min_time, got.w.min_time);
		flag_field("max_hr", want.w.max_hr, got.w.max_hr);
		flag_field("max_time", want.w.max_time, got.w.max_time);
		flag_field("sample_count", want.w.sample_count, got.w.sample_count);
		flag_field("hr_sum", want.w.hr_sum, got.w.hr_sum);
		flag_field("trimp_half", want.w.trimp_half, got.w.trimp_half);
	endtask

	// predict on accepted sample words, check accepted result words, watch for a hang
	always @(posedge clk) begin
		sample_result_t got;
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pending_results = {pending_results, track_sample(s_tdata[HR_W-1:0],
					s_tdata[HR_W+TIME_W-1:HR_W], s_tuser)};
				moved = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got.peak_found = m_tuser;
				got.w = m_tdata[$bits(stats_word_t)-1:0];
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: result word with none expected, got %h", $time, got);
				end else begin
					check_result(pending_results.pop_front(), got);
				end
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver backpressure
	always @(negedge clk)
		m_tready = ($urandom_range(99) >= recv_stall_pct);

	task automatic send_sample(input logic [HR_W-1:0] hr, input logic [TIME_W-1:0] ts,
			input logic restart);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {{(S_W - HR_W - TIME_W){1'b0}}, ts, hr};
		s_tuser = restart;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// drop valid and wait until every expected word has come back
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [HR_W-1:0] bpm);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = bpm;
		bound_bpm[idx] = bpm;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_bounds(input logic [HR_W-1:0] b1, b2, b3, b4, b5, top);
		settle();
		write_bound(REG_BOUND_ZONE1, b1);
		write_bound(REG_BOUND_ZONE2, b2);
		write_bound(REG_BOUND_ZONE3, b3);
		write_bound(REG_BOUND_ZONE4, b4);
		write_bound(REG_BOUND_ZONE5, b5);
		write_bound(REG_BOUND_TOP, top);
	endtask

	// ordered bounds climb from a random floor, otherwise each is independent
	task automatic set_random_bounds(input bit ordered);
		int b [6];
		if (ordered) begin
			b[0] = $urandom_range(40, 120);
			for (int i = 1; i < 6; i++) begin
				b[i] = b[i-1] + $urandom_range(0, 30);
				if (b[i] > 255)
					b[i] = 255;
			end
		end else begin
			foreach (b[i])
				b[i] = $urandom_range(255);
		end
		set_bounds(HR_W'(b[0]), HR_W'(b[1]), HR_W'(b[2]), HR_W'(b[3]), HR_W'(b[4]),
			HR_W'(b[5]));
	endtask

	// each zone's lowest rate under reset bounds, plus both time extremes
	task automatic test_zone_edges();
		byte unsigned rates [10];
		rates = '{0, 94, 95, 114, 133, 152, 171, 190, 191, 255};
		foreach (rates[i]) begin
			workout_s = workout_s + 1'b1;
			if (i == 0)
				send_sample(rates[i], '0, 1'b1);
			else if (i == 9)
				send_sample(rates[i], '1, 1'b0);
			else
				send_sample(rates[i], workout_s, 1'b0);
		end
	endtask

	// plateau peak, dropped candidate, threshold edge, restart with an open candidate
	task automatic test_peak_shapes();
		byte unsigned rates [13];
		bit restarts [13];
		rates = '{100, 120, 120, 120, 110, 130, 140, 100, 90, 96, 95, 120, 110};
		restarts = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};
		foreach (rates[i]) begin
			workout_s = workout_s + 3'd7;
			send_sample(rates[i], workout_s, restarts[i]);
		end
	endtask

	// all bounds at zero, then all at full scale
	task automatic test_bound_extremes();
		set_bounds('0, '0, '0, '0, '0, '0);
		send_sample(8'd0, workout_s, 1'b1);
		send_sample(8'd255, workout_s + 1'b1, 1'b0);
		send_sample(8'd1, workout_s + 2'd2, 1'b0);
		set_bounds('1, '1, '1, '1, '1, '1);
		send_sample(8'd254, workout_s + 2'd3, 1'b0);
		send_sample(8'd255, workout_s + 3'd4, 1'b0);
	endtask

	// heart rate random walk with plateaus, jumps and occasional restarts
	task automatic test_random_workout(input int unsigned idle_pct, input int unsigned stall_pct,
			input int n);
		int rate;
		int step;
		int unsigned r;
		logic [TIME_W-1:0] ts;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		rate = $urandom_range(60, 160);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 10) begin
				rate = $urandom_range(255);
			end else if (r >= 35) begin
				step = $urandom_range(12);
				rate = $urandom_range(1) ? rate + step : rate - step;
				if (rate > 255)
					rate = 255;
				if (rate < 0)
					rate = 0;
			end
			if ($urandom_range(99) < 3) begin
				ts = TIME_W'($urandom);
			end else begin
				workout_s = workout_s + TIME_W'($urandom_range(1, 5));
				ts = workout_s;
			end
			send_sample(HR_W'(rate), ts, r < 2);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_BOUND_ZONE1;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_zone_edges();
		test_peak_shapes();
		test_bound_extremes();

		set_bounds(BOUND_ZONE1_RST, BOUND_ZONE2_RST, BOUND_ZONE3_RST, BOUND_ZONE4_RST,
			BOUND_ZONE5_RST, BOUND_TOP_RST);
		test_random_workout(0, 0, 480);
		set_random_bounds(1'b1);
		test_random_workout(73, 0, 480);
		set_random_bounds(1'b0);
		test_random_workout(0, 73, 480);
		set_random_bounds(1'b1);
		test_random_workout(28, 28, 480);

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
